### rtl/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising edge of clk while rst is low.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that cond never holds at a rising edge of clk while rst is low.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### rtl/ffed_pkg.sv
// Package for the flag framed escape deframer: byte codes and result types.
// Depends on nothing; used by every module of the deframer.
`default_nettype none
package ffed_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_FLAG  = 8'h02;
  localparam logic [7:0] ESC_ESC   = 8'h01;
  localparam logic [9:0] MIN_LIMIT = 10'd2;
  localparam logic [9:0] LIMIT_RESET = 10'd100;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       abrt;
    logic [9:0] len;
  } res_t;

  // One classified item: one or two results.
  typedef struct packed {
    logic two;
    res_t res0;
    res_t res1;
  } rec_t;

  typedef struct packed {
    logic in_frame;
    logic esc_pending;
  } status_t;

endpackage
`default_nettype wire

### rtl/ffed_front.sv
// Front part of the deframer: accepts raw bytes, tracks framing and escapes,
// and turns each byte into a record of zero, one or two results. Uses ffed_pkg.
`default_nettype none
module ffed_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic [7:0]         rx_byte,
  input  wire logic [9:0]         raw_limit,
  output ffed_pkg::rec_t          rec,
  output logic                    rec_push,
  output ffed_pkg::status_t       status
);

  logic       in_frame, in_frame_next;
  logic       esc_pending, esc_pending_next;
  logic [9:0] raw_count, raw_count_next;
  logic [9:0] dec_count, dec_count_next;
  logic [9:0] limit;
  logic [9:0] d1;
  logic [9:0] d2;
  logic       rec_valid;

  always_comb begin
    limit = (raw_limit < ffed_pkg::MIN_LIMIT) ? ffed_pkg::MIN_LIMIT : raw_limit;
    d1 = dec_count + 10'd1;
    d2 = dec_count + 10'd2;
    in_frame_next    = in_frame;
    esc_pending_next = esc_pending;
    raw_count_next   = raw_count;
    dec_count_next   = dec_count;
    rec       = '0;
    rec_valid = 1'b0;
    if (!in_frame) begin
      if (rx_byte == ffed_pkg::FLAG_BYTE) begin
        rec_valid = 1'b1;
        rec.res0  = '{data: ffed_pkg::FLAG_BYTE, first: 1'b1, last: 1'b0,
                      abrt: 1'b0, len: 10'd1};
        in_frame_next    = 1'b1;
        esc_pending_next = 1'b0;
        raw_count_next   = 10'd1;
        dec_count_next   = 10'd1;
      end
    end else if (raw_count >= limit) begin
      rec_valid = 1'b1;
      rec.res0  = '{data: 8'h00, first: 1'b0, last: 1'b1, abrt: 1'b1, len: dec_count};
      in_frame_next    = 1'b0;
      esc_pending_next = 1'b0;
      raw_count_next   = '0;
      dec_count_next   = '0;
    end else begin
      raw_count_next = raw_count + 10'd1;
      if (esc_pending) begin
        esc_pending_next = 1'b0;
        rec_valid = 1'b1;
        dec_count_next = d1;
        if (rx_byte == ffed_pkg::ESC_FLAG) begin
          rec.res0 = '{data: ffed_pkg::FLAG_BYTE, first: 1'b0, last: 1'b0,
                       abrt: 1'b0, len: d1};
        end else if (rx_byte == ffed_pkg::ESC_ESC) begin
          rec.res0 = '{data: ffed_pkg::ESC_BYTE, first: 1'b0, last: 1'b0,
                       abrt: 1'b0, len: d1};
        end else begin
          rec.res0 = '{data: ffed_pkg::ESC_BYTE, first: 1'b0, last: 1'b0,
                       abrt: 1'b0, len: d1};
          if (rx_byte == ffed_pkg::FLAG_BYTE) begin
            rec.two  = 1'b1;
            rec.res1 = '{data: ffed_pkg::FLAG_BYTE, first: 1'b0, last: 1'b1,
                         abrt: 1'b0, len: d2};
            in_frame_next  = 1'b0;
            raw_count_next = '0;
            dec_count_next = '0;
          end else if (rx_byte == ffed_pkg::ESC_BYTE) begin
            esc_pending_next = 1'b1;
          end else begin
            rec.two  = 1'b1;
            rec.res1 = '{data: rx_byte, first: 1'b0, last: 1'b0, abrt: 1'b0, len: d2};
            dec_count_next = d2;
          end
        end
      end else if (rx_byte == ffed_pkg::FLAG_BYTE) begin
        rec_valid = 1'b1;
        rec.res0  = '{data: ffed_pkg::FLAG_BYTE, first: 1'b0, last: 1'b1,
                      abrt: 1'b0, len: d1};
        in_frame_next  = 1'b0;
        raw_count_next = '0;
        dec_count_next = '0;
      end else if (rx_byte == ffed_pkg::ESC_BYTE) begin
        esc_pending_next = 1'b1;
      end else begin
        rec_valid = 1'b1;
        rec.res0  = '{data: rx_byte, first: 1'b0, last: 1'b0, abrt: 1'b0, len: d1};
        dec_count_next = d1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      esc_pending <= 1'b0;
      raw_count   <= '0;
      dec_count   <= '0;
    end else if (accept) begin
      in_frame    <= in_frame_next;
      esc_pending <= esc_pending_next;
      raw_count   <= raw_count_next;
      dec_count   <= dec_count_next;
    end
  end

  assign rec_push = accept && rec_valid;
  assign status   = '{in_frame: in_frame, esc_pending: esc_pending};

endmodule
`default_nettype wire

### rtl/ffed_queue.sv
// Short record queue between the front and back parts of the deframer.
// Uses ffed_pkg for the record type.
`default_nettype none
module ffed_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_en,
  input  ffed_pkg::rec_t      wr_rec,
  output logic                full,
  input  wire logic           rd_en,
  output ffed_pkg::rec_t      rd_rec,
  output logic                rd_valid
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  ffed_pkg::rec_t mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_wr;
  logic            do_rd;

  assign full     = (count == CntW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_rec   = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/ffed_back.sv
// Back part of the deframer: takes records from the queue and delivers their
// results one at a time from an output register. Uses ffed_pkg.
`default_nettype none
module ffed_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  ffed_pkg::rec_t      q_rec,
  input  wire logic           q_valid,
  output logic                q_pop,
  input  wire logic           pop,
  output logic                empty,
  output ffed_pkg::res_t      res
);

  ffed_pkg::rec_t cur;
  logic           cur_valid;
  logic           sel;
  logic           taken;
  logic           done;

  assign taken = pop && cur_valid;
  assign done  = taken && (sel || !cur.two);
  assign q_pop = q_valid && (!cur_valid || done);
  assign empty = !cur_valid;
  assign res   = sel ? cur.res1 : cur.res0;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      sel       <= 1'b0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      sel       <= 1'b0;
    end else if (done) begin
      cur_valid <= 1'b0;
      sel       <= 1'b0;
    end else if (taken) begin
      sel <= 1'b1;
    end
  end

endmodule
`default_nettype wire

### rtl/flag_framed_escape_deframer_unit.sv
// Top level of the flag framed escape deframer: front, record queue and back.
// Depends on ffed_pkg, ffed_front, ffed_queue, ffed_back and assert_macros.svh.
//
// The unit removes 0x7E framing and 0x7D escapes from a byte stream. One raw
// byte is accepted in every cycle in which push is high and full is low;
// bytes outside a frame are dropped without a result. Results leave one per
// cycle from an output register while pop is high, so a byte that yields two
// results (an escape followed by an ordinary byte or a flag) takes two pops;
// the record queue of QUEUE_DEPTH entries absorbs that and any stall of the
// consumer. Each result passes the record queue, then the output register.
// raw_limit must be written via raw_limit_wr_en while idle; not enforced here.
`default_nettype none
`include "assert_macros.svh"
module flag_framed_escape_deframer_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] rx_byte,
  input  wire logic       pop,
  output logic            empty,
  output logic [7:0]      out_byte,
  output logic            is_first,
  output logic            is_last,
  output logic            aborted,
  output logic [9:0]      decoded_length,
  input  wire logic       raw_limit_wr_en,
  input  wire logic [9:0] raw_limit_wr_data
);

  logic [9:0]        raw_limit;
  logic              accept;
  ffed_pkg::rec_t    f_rec;
  logic              f_push;
  ffed_pkg::status_t status;
  ffed_pkg::rec_t    q_rec;
  logic              q_valid;
  logic              q_pop;
  ffed_pkg::res_t    res;
  logic              drop_byte;
  logic              hunt_clean;
  logic              abort_ok;
  logic              first_ok;
  logic              stray_esc;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_limit <= ffed_pkg::LIMIT_RESET;
    end else if (raw_limit_wr_en) begin
      raw_limit <= raw_limit_wr_data;
    end
  end

  assign accept = push && !full;

  ffed_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .raw_limit (raw_limit),
    .rec       (f_rec),
    .rec_push  (f_push),
    .status    (status)
  );

  ffed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (f_push),
    .wr_rec   (f_rec),
    .full     (full),
    .rd_en    (q_pop),
    .rd_rec   (q_rec),
    .rd_valid (q_valid)
  );

  ffed_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_rec   (q_rec),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  assign out_byte       = res.data;
  assign is_first       = res.first;
  assign is_last        = res.last;
  assign aborted        = res.abrt;
  assign decoded_length = res.len;

  assign drop_byte  = accept && !status.in_frame && rx_byte != ffed_pkg::FLAG_BYTE;
  assign hunt_clean = !status.in_frame && !status.esc_pending;
  assign abort_ok   = is_last && !is_first && out_byte == 8'h00;
  assign first_ok   = out_byte == ffed_pkg::FLAG_BYTE && decoded_length == 10'd1 && !is_last;
  assign stray_esc  = status.esc_pending && !status.in_frame;

  `ASSERT_CLK(a_hunt_drop, clk, rst, drop_byte |=> hunt_clean, "non-flag byte left hunting")
  `ASSERT_CLK(a_abort_form, clk, rst, !empty && aborted |-> abort_ok, "malformed abort item")
  `ASSERT_CLK(a_first_form, clk, rst, !empty && is_first |-> first_ok, "malformed opening item")
  `ASSERT_NEVER(a_pend_hunt, clk, rst, stray_esc, "escape pending outside a frame")

endmodule
`default_nettype wire

### dv/flag_framed_escape_deframer_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for flag_framed_escape_deframer_unit: a stimulus table,
// then random frames under several raw limits, checked by a cycle-free predictor.
// Depends on ffed_pkg and the deframer RTL only.
module flag_framed_escape_deframer_unit_test;
  import ffed_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 75;
  localparam res_t NO_RES = '0;

  typedef enum logic [1:0] {ROW_CHECKED, ROW_SILENT, ROW_TYPED, ROW_LIMIT} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] b;
    logic [9:0] cfg;
    res_t       typed;
  } row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic       pop = 1'b0;
  logic       raw_limit_wr_en = 1'b0;
  logic [9:0] raw_limit_wr_data = 10'd0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       is_first;
  logic       is_last;
  logic       aborted;
  logic [9:0] decoded_length;

  logic       inside_frame = 1'b0;
  logic       esc_pend = 1'b0;
  logic [9:0] raw_cnt = 10'd0;
  logic [9:0] dec_cnt = 10'd0;
  logic [9:0] frame_limit = LIMIT_RESET;

  res_t        pending_results[$];
  row_t        dir_rows[$];
  int unsigned mismatches = 0;
  int unsigned fed = 0;
  int unsigned burst_left = 0;
  int unsigned cycle_cnt = 0;
  logic [15:0] pop_pat = 16'hFFFF;
  logic [3:0]  pat_pos = 4'd0;
  int unsigned pat_age = 0;

  flag_framed_escape_deframer_unit DUT (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .rx_byte(rx_byte),
    .pop(pop),
    .empty(empty),
    .out_byte(out_byte),
    .is_first(is_first),
    .is_last(is_last),
    .aborted(aborted),
    .decoded_length(decoded_length),
    .raw_limit_wr_en(raw_limit_wr_en),
    .raw_limit_wr_data(raw_limit_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic res_t mk_res(input logic [7:0] d, input logic f, input logic l,
                                  input logic a, input logic [9:0] n);
    res_t r;
    r.data = d;
    r.first = f;
    r.last = l;
    r.abrt = a;
    r.len = n;
    return r;
  endfunction

  task automatic emit_decoded(input logic [7:0] d, input logic last);
    dec_cnt = dec_cnt + 10'd1;
    pending_results.push_back(mk_res(d, 1'b0, last, 1'b0, dec_cnt));
  endtask

  task automatic return_to_hunt();
    inside_frame = 1'b0;
    esc_pend = 1'b0;
    raw_cnt = 10'd0;
    dec_cnt = 10'd0;
  endtask

  task automatic unstuff_byte(input logic [7:0] b);
    logic [9:0] eff;
    eff = (frame_limit < MIN_LIMIT) ? MIN_LIMIT : frame_limit;
    if (!inside_frame) begin
      if (b != FLAG_BYTE) return;
      inside_frame = 1'b1;
      esc_pend = 1'b0;
      raw_cnt = 10'd1;
      dec_cnt = 10'd1;
      pending_results.push_back(mk_res(FLAG_BYTE, 1'b1, 1'b0, 1'b0, 10'd1));
      return;
    end
    if (raw_cnt >= eff) begin
      pending_results.push_back(mk_res(8'h00, 1'b0, 1'b1, 1'b1, dec_cnt));
      return_to_hunt();
      return;
    end
    raw_cnt = raw_cnt + 10'd1;
    if (esc_pend) begin
      esc_pend = 1'b0;
      if (b == ESC_FLAG) begin
        emit_decoded(FLAG_BYTE, 1'b0);
        return;
      end
      if (b == ESC_ESC) begin
        emit_decoded(ESC_BYTE, 1'b0);
        return;
      end
      emit_decoded(ESC_BYTE, 1'b0);
    end
    if (b == FLAG_BYTE) begin
      emit_decoded(FLAG_BYTE, 1'b1);
      return_to_hunt();
    end else if (b == ESC_BYTE) begin
      esc_pend = 1'b1;
    end else begin
      emit_decoded(b, 1'b0);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input row_kind_t kind, input res_t typed);
    int unsigned n0;
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 6)) begin
        @(negedge clk);
        push <= 1'b0;
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    push <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (full);
    fed++;
    n0 = pending_results.size();
    unstuff_byte(b);
    if (kind != ROW_CHECKED) begin
      while (pending_results.size() > n0) void'(pending_results.pop_back());
      if (kind == ROW_TYPED) pending_results.push_back(typed);
    end
  endtask

  task automatic feed(input logic [7:0] b);
    send_byte(b, ROW_CHECKED, NO_RES);
  endtask

  task automatic write_limit(input logic [9:0] v);
    @(negedge clk);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    raw_limit_wr_en <= 1'b1;
    raw_limit_wr_data <= v;
    @(negedge clk);
    raw_limit_wr_en <= 1'b0;
    frame_limit = v;
  endtask

  task automatic send_frame(input bit max_plain);
    int body;
    int n;
    int unsigned pick;
    int eff;
    logic [7:0] v;
    eff = int'((frame_limit < MIN_LIMIT) ? MIN_LIMIT : frame_limit);
    if (!max_plain && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) feed(8'($urandom_range(0, 255)));
    end
    feed(FLAG_BYTE);
    if (max_plain) body = eff - 2;
    else if ($urandom_range(0, 5) == 0) body = eff - 3 + int'($urandom_range(0, 3));
    else body = $urandom_range(0, 12);
    n = 0;
    while (n < body) begin
      pick = max_plain ? 0 : $urandom_range(0, 9);
      if (pick < 7) begin
        v = 8'($urandom_range(0, 255));
        if (v == FLAG_BYTE || v == ESC_BYTE) v = v ^ 8'h80;
        feed(v);
        n += 1;
      end else begin
        feed(ESC_BYTE);
        if (pick == 7) feed(ESC_FLAG);
        else if (pick == 8) feed(ESC_ESC);
        else feed(8'($urandom_range(0, 255)));
        n += 2;
      end
    end
    if (max_plain || $urandom_range(0, 15) != 0) feed(FLAG_BYTE);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pat_age == 0) begin
        case ($urandom_range(0, 2))
          0: pop_pat <= 16'hFFFF;
          1: pop_pat <= 16'($urandom);
          default: pop_pat <= 16'h1111;
        endcase
        pat_age <= $urandom_range(20, 80);
      end else begin
        pat_age <= pat_age - 1;
      end
      pop <= pop_pat[pat_pos];
      pat_pos <= pat_pos + 4'd1;
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: byte %h first %b last %b abort %b len %0d",
                   out_byte, is_first, is_last, aborted, decoded_length);
      end else begin
        want = pending_results.pop_front();
        if (out_byte !== want.data || is_first !== want.first || is_last !== want.last ||
            aborted !== want.abrt || decoded_length !== want.len) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected byte %h first %b last %b abort %b len %0d, ",
                      "got byte %h first %b last %b abort %b len %0d"},
                     want.data, want.first, want.last, want.abrt, want.len,
                     out_byte, is_first, is_last, aborted, decoded_length);
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[flag_framed_escape_deframer_unit] ERROR");
    $finish;
  end

  initial begin
    logic [9:0] phase_lim [10];
    int unsigned start;
    dir_rows.push_back('{ROW_SILENT, 8'h00, 10'd0, NO_RES});
    dir_rows.push_back('{ROW_SILENT, 8'hFF, 10'd0, NO_RES});
    dir_rows.push_back('{ROW_TYPED, FLAG_BYTE, 10'd0,
                         mk_res(FLAG_BYTE, 1'b1, 1'b0, 1'b0, 10'd1)});
    dir_rows.push_back('{ROW_TYPED, 8'h00, 10'd0, mk_res(8'h00, 1'b0, 1'b0, 1'b0, 10'd2)});
    dir_rows.push_back('{ROW_TYPED, 8'hFF, 10'd0, mk_res(8'hFF, 1'b0, 1'b0, 1'b0, 10'd3)});
    dir_rows.push_back('{ROW_SILENT, ESC_BYTE, 10'd0, NO_RES});
    dir_rows.push_back('{ROW_TYPED, ESC_FLAG, 10'd0,
                         mk_res(FLAG_BYTE, 1'b0, 1'b0, 1'b0, 10'd4)});
    dir_rows.push_back('{ROW_SILENT, ESC_BYTE, 10'd0, NO_RES});
    dir_rows.push_back('{ROW_TYPED, ESC_ESC, 10'd0,
                         mk_res(ESC_BYTE, 1'b0, 1'b0, 1'b0, 10'd5)});
    dir_rows.push_back('{ROW_SILENT, ESC_BYTE, 10'd0, NO_RES});
    dir_rows.push_back('{ROW_CHECKED, 8'h55, 10'd0, NO_RES});
    dir_rows.push_back('{ROW_SILENT, ESC_BYTE, 10'd0, NO_RES});
    dir_rows.push_back('{ROW_CHECKED, ESC_BYTE, 10'd0, NO_RES});
    dir_rows.push_back('{ROW_CHECKED, FLAG_BYTE, 10'd0, NO_RES});
    dir_rows.push_back('{ROW_SILENT, ESC_BYTE, 10'd0, NO_RES});
    dir_rows.push_back('{ROW_TYPED, FLAG_BYTE, 10'd0,
                         mk_res(FLAG_BYTE, 1'b1, 1'b0, 1'b0, 10'd1)});
    dir_rows.push_back('{ROW_TYPED, FLAG_BYTE, 10'd0,
                         mk_res(FLAG_BYTE, 1'b0, 1'b1, 1'b0, 10'd2)});
    dir_rows.push_back('{ROW_LIMIT, 8'h00, 10'd0, NO_RES});
    dir_rows.push_back('{ROW_TYPED, FLAG_BYTE, 10'd0,
                         mk_res(FLAG_BYTE, 1'b1, 1'b0, 1'b0, 10'd1)});
    dir_rows.push_back('{ROW_TYPED, 8'h41, 10'd0, mk_res(8'h41, 1'b0, 1'b0, 1'b0, 10'd2)});
    dir_rows.push_back('{ROW_TYPED, FLAG_BYTE, 10'd0,
                         mk_res(8'h00, 1'b0, 1'b1, 1'b1, 10'd2)});
    dir_rows.push_back('{ROW_TYPED, FLAG_BYTE, 10'd0,
                         mk_res(FLAG_BYTE, 1'b1, 1'b0, 1'b0, 10'd1)});
    dir_rows.push_back('{ROW_SILENT, ESC_BYTE, 10'd0, NO_RES});
    dir_rows.push_back('{ROW_TYPED, ESC_FLAG, 10'd0,
                         mk_res(8'h00, 1'b0, 1'b1, 1'b1, 10'd1)});

    phase_lim = '{10'd1023, 10'd1, 10'd3, 10'd2, 10'd5, 10'd0, 10'd8, 10'd100, 10'd0, 10'd0};
    phase_lim[8] = 10'($urandom_range(4, 40));
    phase_lim[9] = 10'($urandom_range(4, 40));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_LIMIT) write_limit(dir_rows[i].cfg);
      else send_byte(dir_rows[i].b, dir_rows[i].kind, dir_rows[i].typed);
    end

    foreach (phase_lim[p]) begin
      write_limit(phase_lim[p]);
      start = fed;
      if (phase_lim[p] == 10'd1023) send_frame(1'b1);
      while (fed - start < PHASE_ITEMS) send_frame(1'b0);
    end

    @(negedge clk);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[flag_framed_escape_deframer_unit] OK");
    end else begin
      $display("[flag_framed_escape_deframer_unit] ERROR");
    end
    $finish;
  end
endmodule

### flag_framed_escape_deframer_unit.f
+incdir+rtl
rtl/ffed_pkg.sv
rtl/ffed_front.sv
rtl/ffed_queue.sv
rtl/ffed_back.sv
rtl/flag_framed_escape_deframer_unit.sv
dv/flag_framed_escape_deframer_unit_test.sv
